// ===== src/cbt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CIGAR binary to text: shared definitions
// Types, constants and the operation letter decoder used by the front end,
// the entry queue and the character emitter.
// ----------------------------------------------------------------------------
package cbt_pkg;

  localparam int unsigned MAX_DIGITS = 6;
  localparam int unsigned LEN_W      = 20;             // lengths below the limit
  localparam int unsigned CNT_W      = 3;              // holds 0 .. MAX_DIGITS

  localparam logic [27:0] LEN_LIMIT  = 28'd1000000;
  localparam logic [3:0]  OP_MASK    = 4'hf;

  // Reciprocal of ten scaled by 2^23, exact for every length below the limit.
  localparam logic [LEN_W-1:0] RECIP10  = 20'hCCCCD;
  localparam int unsigned      RECIP_SH = 23;
  localparam int unsigned      PROD_W   = 2 * LEN_W;

  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_NUL  = 8'h00;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_STAR = 2'd1,
    KIND_LONG = 2'd2
  } cbt_kind_e;

  typedef struct packed {
    cbt_kind_e                   kind;
    logic [MAX_DIGITS-1:0][3:0]  digits;   // least significant digit at index 0
    logic [CNT_W-1:0]            nd;       // number of digits held
    logic [7:0]                  letter;
  } cbt_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cbt_q_stat_t;

  function automatic logic [7:0] op_letter(input logic [3:0] code);
    logic [7:0] ch;
    unique case (code & OP_MASK)
      4'd0:    ch = 8'h4D;  // M
      4'd1:    ch = 8'h49;  // I
      4'd2:    ch = 8'h44;  // D
      4'd3:    ch = 8'h4E;  // N
      4'd4:    ch = 8'h53;  // S
      4'd5:    ch = 8'h48;  // H
      4'd6:    ch = 8'h50;  // P
      4'd7:    ch = 8'h3D;  // =
      4'd8:    ch = 8'h58;  // X
      default: ch = CHAR_NUL;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== src/cigar_binary_to_text_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CIGAR binary to text core
// Turns one binary CIGAR operation word into its textual form, one character
// per output strobe.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: an operation word transfer happens on a rising edge where
//   start_i is high and busy_o is low. op_word_i carries the length in bits
//   31..4 and the operation code in bits 3..0; no_ops_i asks for a lone '*'.
//   Output channel: each character is shown for exactly one cycle with
//   text_valid_o high. last_o marks the final character of an operation, and
//   too_long_o flags a length of one million or more (a single NUL result).
// Timing:
//   The front end converts the length with one divide-by-ten step per cycle
//   and can take a new operation word as soon as it hands its entry to the
//   queue. The emitter sends one character per cycle, n + 1 for n digits.
//   The first character appears once the front end has converted the length
//   (no conversion for '*' or an over-long length) and pushed the entry, and
//   the emitter has taken it from the queue. A two-entry queue between the
//   two halves keeps both busy.
// Reset:
//   rst_ni clears the converter, the queue and the emitter; nothing is in
//   flight afterwards. The receiver cannot stall: characters are pushed out.
// ----------------------------------------------------------------------------
module cigar_binary_to_text_core
  import cbt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] op_word_i,
  input  wire logic        no_ops_i,
  output logic             text_valid_o,
  output logic [7:0]       text_char_o,
  output logic             last_o,
  output logic             too_long_o
);

  // Converted entries travel from the front end to the emitter via the queue.
  logic        push;
  logic        pop;
  cbt_entry_t  push_entry;
  cbt_entry_t  head_entry;
  cbt_q_stat_t q_stat;

  cbt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .op_word_i (op_word_i),
    .no_ops_i  (no_ops_i),
    .busy_o    (busy_o),
    .push_o    (push),
    .entry_o   (push_entry),
    .q_stat_i  (q_stat)
  );

  cbt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .pop_data_o  (head_entry),
    .stat_o      (q_stat)
  );

  // The emitter pulls the next entry in the same cycle as it sends the last
  // character of the current one, so back-to-back operations leave no gap.
  cbt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (head_entry),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .text_valid_o (text_valid_o),
    .text_char_o  (text_char_o),
    .last_o       (last_o),
    .too_long_o   (too_long_o)
  );

`ifndef SYNTH
  // An over-long length yields a single NUL character that closes the item.
  a_long_is_lone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (text_valid_o && too_long_o) |-> (last_o && text_char_o == CHAR_NUL))
    else $error("too_long result is not a lone terminating NUL");

  // Every character before the last one of an operation is a decimal digit.
  a_digits_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (text_valid_o && !last_o) |->
      (text_char_o >= CHAR_ZERO && text_char_o <= CHAR_NINE && !too_long_o))
    else $error("non-final character is not a decimal digit");

  // A star only ever appears as the complete text of an operation.
  a_star_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (text_valid_o && text_char_o == CHAR_STAR) |-> (last_o && !too_long_o))
    else $error("star emitted other than as a complete result");
`endif

endmodule
`default_nettype wire

// ===== src/cbt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CIGAR binary to text: front end
// Accepts operation words, classifies them and converts text lengths to
// decimal, one digit per cycle, before handing the entry to the queue.
// ----------------------------------------------------------------------------
module cbt_front
  import cbt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] op_word_i,
  input  wire logic        no_ops_i,
  output logic             busy_o,
  output logic             push_o,
  output cbt_entry_t       entry_o,
  input  cbt_q_stat_t      q_stat_i
);

  logic                       act_q, act_d;
  logic                       done_q, done_d;
  cbt_kind_e                  kind_q, kind_d;
  logic [LEN_W-1:0]           len_q, len_d;
  logic [MAX_DIGITS-1:0][3:0] digits_q, digits_d;
  logic [CNT_W-1:0]           nd_q, nd_d;
  logic [7:0]                 letter_q, letter_d;

  logic                       accept;
  logic [PROD_W-1:0]          prod;
  logic [LEN_W-1:0]           quot;
  logic [LEN_W-1:0]           quot_x10;
  logic [LEN_W-1:0]           rem;

  assign push_o = act_q && done_q && !q_stat_i.full;
  assign busy_o = act_q && !(done_q && !q_stat_i.full);
  assign accept = start_i && !busy_o;

  // Divide by ten through the scaled reciprocal; the remainder is the digit.
  assign prod     = PROD_W'(len_q) * PROD_W'(RECIP10);
  assign quot     = LEN_W'(prod >> RECIP_SH);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem      = len_q - quot_x10;

  always_comb begin
    act_d    = act_q;
    done_d   = done_q;
    kind_d   = kind_q;
    len_d    = len_q;
    digits_d = digits_q;
    nd_d     = nd_q;
    letter_d = letter_q;
    if (push_o) begin
      act_d = 1'b0;
    end
    if (accept) begin
      act_d    = 1'b1;
      len_d    = op_word_i[LEN_W+3:4];
      nd_d     = '0;
      letter_d = op_letter(op_word_i[3:0]);
      if (no_ops_i) begin
        kind_d = KIND_STAR;
        done_d = 1'b1;
      end else if (op_word_i[31:4] >= LEN_LIMIT) begin
        kind_d = KIND_LONG;
        done_d = 1'b1;
      end else begin
        kind_d = KIND_TEXT;
        done_d = 1'b0;
      end
    end else if (act_q && !done_q) begin
      digits_d[nd_q] = rem[3:0];
      nd_d           = nd_q + CNT_W'(1);
      len_d          = quot;
      done_d         = (quot == '0) || (nd_q == CNT_W'(MAX_DIGITS - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      done_q <= 1'b0;
      nd_q   <= '0;
      kind_q <= KIND_TEXT;
    end else begin
      act_q  <= act_d;
      done_q <= done_d;
      nd_q   <= nd_d;
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    digits_q <= digits_d;
    letter_q <= letter_d;
  end

  always_comb begin
    entry_o.kind   = kind_q;
    entry_o.digits = digits_q;
    entry_o.nd     = nd_q;
    entry_o.letter = letter_q;
  end

endmodule
`default_nettype wire

// ===== src/cbt_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CIGAR binary to text: entry queue
// Two-entry queue that lets the converter and the emitter stall independently.
// ----------------------------------------------------------------------------
module cbt_queue
  import cbt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  cbt_entry_t  push_data_i,
  input  wire logic   pop_i,
  output cbt_entry_t  pop_data_o,
  output cbt_q_stat_t stat_o
);

  cbt_entry_t  mem_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full))
    else $error("entry queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && stat_o.empty))
    else $error("entry queue read while empty");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("entry queue pointers disagree with fill level");
`endif

endmodule
`default_nettype wire

// ===== src/cbt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CIGAR binary to text: character emitter
// Takes converted entries from the queue and emits one character per cycle:
// digits, most significant first, then the operation letter; or '*' or NUL.
// ----------------------------------------------------------------------------
module cbt_back
  import cbt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  cbt_entry_t  entry_i,
  input  cbt_q_stat_t q_stat_i,
  output logic        pop_o,
  output logic        text_valid_o,
  output logic [7:0]  text_char_o,
  output logic        last_o,
  output logic        too_long_o
);

  logic             cur_valid_q;
  cbt_entry_t       cur_q;
  logic [CNT_W-1:0] pos_q;
  logic             finishing;
  logic [CNT_W-1:0] dig_idx;

  assign finishing = cur_valid_q && ((cur_q.kind != KIND_TEXT) || (pos_q == '0));
  assign pop_o     = (!cur_valid_q || finishing) && !q_stat_i.empty;
  assign dig_idx   = pos_q - CNT_W'(1);

  always_comb begin
    text_valid_o = cur_valid_q;
    text_char_o  = CHAR_NUL;
    last_o       = 1'b0;
    too_long_o   = 1'b0;
    unique case (cur_q.kind)
      KIND_STAR: begin
        text_char_o = CHAR_STAR;
        last_o      = 1'b1;
      end
      KIND_LONG: begin
        last_o      = 1'b1;
        too_long_o  = 1'b1;
      end
      KIND_TEXT: begin
        if (pos_q != '0) begin
          text_char_o = CHAR_ZERO + {4'b0000, cur_q.digits[dig_idx]};
        end else begin
          text_char_o = cur_q.letter;
          last_o      = 1'b1;
        end
      end
      default: begin
        text_char_o = CHAR_NUL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        pos_q       <= entry_i.nd;
      end else if (finishing) begin
        cur_valid_q <= 1'b0;
      end else if (cur_valid_q) begin
        pos_q <= dig_idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
  end

endmodule
`default_nettype wire
